FILE: rtl/core/ptfk_pkg.sv
// Shared constants, types and arithmetic helpers of the pan-tilt kinematics block.
`timescale 1ns / 1ps

package ptfk_pkg;

    // Number of CORDIC micro-rotations; the arctangent table covers up to 24.
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int LANES         = 2;

    // Angle constants in Q3.29 and the CORDIC gain in Q29.
    localparam logic signed [32:0] PI_Q29      = 33'sd1686629713;
    localparam logic signed [32:0] HALF_PI_Q29 = 33'sd843314857;
    localparam logic signed [31:0] GAIN_Q29    = 32'sd326016437;

    // Camera offset of 0.048 m in units of 2^-20 m.
    localparam logic signed [16:0] H_Q20 = 17'sd50332;

    localparam logic signed [31:0] ATAN_Q29 [TABLE_LEN] = '{
        32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579,
        32'sd33510843,  32'sd16771758,  32'sd8387925,   32'sd4194219,
        32'sd2097141,   32'sd1048575,   32'sd524288,    32'sd262144,
        32'sd131072,    32'sd65536,     32'sd32768,     32'sd16384,
        32'sd8192,      32'sd4096,      32'sd2048,      32'sd1024,
        32'sd512,       32'sd256,       32'sd128,       32'sd64
    };

    typedef logic signed [15:0] t_angle;
    typedef logic signed [15:0] t_q14;
    typedef logic signed [16:0] t_trans;

    // Register indexes of the configuration port.
    typedef enum logic [0:0] {
        t_REG_DH_MODEL     = 1'b0,
        t_REG_OUTPUT_FRAME = 1'b1
    } t_reg_idx;

    // Product of two Q1.14 values, rounded to nearest with ties upwards.
    function automatic t_q14 mul14(input t_q14 a, input t_q14 b);
        logic signed [31:0] p;
        p = a * b;
        p = p + 32'sd8192;
        return t_q14'(p >>> 14);
    endfunction

endpackage

FILE: rtl/core/ptfk_sincos.sv
// Pipelined CORDIC rotator giving the cosine and sine of two angles side by side.
`timescale 1ns / 1ps

module ptfk_sincos (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  ptfk_pkg::t_angle     i_angle [ptfk_pkg::LANES],
    output logic                 o_valid,
    output ptfk_pkg::t_q14       o_cos   [ptfk_pkg::LANES],
    output ptfk_pkg::t_q14       o_sin   [ptfk_pkg::LANES]
);

    localparam int N = ptfk_pkg::CORDIC_STAGES;

    logic                 r_vld  [N+1];
    logic                 r_flip [ptfk_pkg::LANES][N+1];
    logic signed [31:0]   r_x    [ptfk_pkg::LANES][N+1];
    logic signed [31:0]   r_y    [ptfk_pkg::LANES][N+1];
    logic signed [31:0]   r_z    [ptfk_pkg::LANES][N+1];

    logic signed [32:0]   n_z    [ptfk_pkg::LANES];
    logic                 n_flip [ptfk_pkg::LANES];
    logic signed [31:0]   n_xf   [ptfk_pkg::LANES];
    logic signed [31:0]   n_yf   [ptfk_pkg::LANES];
    ptfk_pkg::t_q14       n_cos  [ptfk_pkg::LANES];
    ptfk_pkg::t_q14       n_sin  [ptfk_pkg::LANES];

    function automatic ptfk_pkg::t_q14 round_clamp(input logic signed [31:0] v);
        logic signed [32:0] t;
        t = {v[31], v} + 33'sd16384;
        t = t >>> 15;
        if (t > 33'sd16384) begin
            return 16'sd16384;
        end else if (t < -33'sd16384) begin
            return -16'sd16384;
        end
        return ptfk_pkg::t_q14'(t);
    endfunction

    // Fold the widened angle into the range of plus or minus a quarter turn.
    always_comb begin
        for (int l = 0; l < ptfk_pkg::LANES; l++) begin
            n_z[l]    = $signed({i_angle[l][15], i_angle[l], 16'h0000});
            n_flip[l] = 1'b0;
            if (n_z[l] > ptfk_pkg::HALF_PI_Q29) begin
                n_z[l]    = n_z[l] - ptfk_pkg::PI_Q29;
                n_flip[l] = 1'b1;
            end else if (n_z[l] < -ptfk_pkg::HALF_PI_Q29) begin
                n_z[l]    = n_z[l] + ptfk_pkg::PI_Q29;
                n_flip[l] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < ptfk_pkg::LANES; l++) begin
            r_x[l][0]    <= ptfk_pkg::GAIN_Q29;
            r_y[l][0]    <= '0;
            r_z[l][0]    <= n_z[l][31:0];
            r_flip[l][0] <= n_flip[l];
            for (int k = 0; k < N; k++) begin
                r_flip[l][k+1] <= r_flip[l][k];
                if (!r_z[l][k][31]) begin
                    r_x[l][k+1] <= r_x[l][k] - (r_y[l][k] >>> k);
                    r_y[l][k+1] <= r_y[l][k] + (r_x[l][k] >>> k);
                    r_z[l][k+1] <= r_z[l][k] - ptfk_pkg::ATAN_Q29[k];
                end else begin
                    r_x[l][k+1] <= r_x[l][k] + (r_y[l][k] >>> k);
                    r_y[l][k+1] <= r_y[l][k] - (r_x[l][k] >>> k);
                    r_z[l][k+1] <= r_z[l][k] + ptfk_pkg::ATAN_Q29[k];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < ptfk_pkg::LANES; l++) begin
            n_xf[l]  = r_flip[l][N] ? -r_x[l][N] : r_x[l][N];
            n_yf[l]  = r_flip[l][N] ? -r_y[l][N] : r_y[l][N];
            n_cos[l] = round_clamp(n_xf[l]);
            n_sin[l] = round_clamp(n_yf[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < ptfk_pkg::LANES; l++) begin
            o_cos[l] <= n_cos[l];
            o_sin[l] <= n_sin[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N; k++) begin
                r_vld[k] <= 1'b0;
            end
            o_valid <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 0; k < N; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
            o_valid <= r_vld[N];
        end
    end

endmodule

FILE: rtl/core/pan_tilt_forward_kinematics_unit.sv
// Top level of the pan-tilt head forward kinematics pipeline.
`timescale 1ns / 1ps

// A word carries a pan and a tilt angle in Q3.13 radians. It is taken at a
// rising edge where start is high; busy is always low, so a new word may be
// offered in every cycle and the block sustains one word per clock.
// Each word yields exactly one result word: a 3x3 rotation in Q1.14 and a
// translation in units of 2^-20 m, shown on the o_ ports for a single cycle
// while o_valid is high. The pipeline registers the work in stages: one
// folds the angles, one per micro-rotation, one rounds the sine and
// cosine, one forms the products and one applies the frame and offset.
// Results cannot be held off by the receiver; none is ever dropped because
// every stage advances on every clock.
// The configuration port writes dh_model (index 0) and output_frame
// (index 1); only bit 0 of the data is kept. Both should only be changed
// while no word is in flight, as the later stages read them directly.
// A synchronous active-low reset clears the valid bits in flight and sets
// both configuration registers to zero; data registers are not reset.

module pan_tilt_forward_kinematics_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ptfk_pkg::t_angle    i_pan_angle,
    input  ptfk_pkg::t_angle    i_tilt_angle,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_idx,
    input  logic [0:0]          i_cfg_data,
    output logic                o_valid,
    output ptfk_pkg::t_q14      o_rot_r0c0,
    output ptfk_pkg::t_q14      o_rot_r0c1,
    output ptfk_pkg::t_q14      o_rot_r0c2,
    output ptfk_pkg::t_q14      o_rot_r1c0,
    output ptfk_pkg::t_q14      o_rot_r1c1,
    output ptfk_pkg::t_q14      o_rot_r1c2,
    output ptfk_pkg::t_q14      o_rot_r2c0,
    output ptfk_pkg::t_q14      o_rot_r2c1,
    output ptfk_pkg::t_q14      o_rot_r2c2,
    output ptfk_pkg::t_trans    o_trans_x,
    output ptfk_pkg::t_trans    o_trans_y,
    output ptfk_pkg::t_trans    o_trans_z
);

    logic                 r_dh_model;
    logic                 r_output_frame;

    ptfk_pkg::t_angle     w_angle [ptfk_pkg::LANES];
    ptfk_pkg::t_q14       w_cos   [ptfk_pkg::LANES];
    ptfk_pkg::t_q14       w_sin   [ptfk_pkg::LANES];
    logic                 w_sc_vld;

    // Product stage: the end-effector rotation with the model's signs applied.
    logic                 r_p_vld;
    ptfk_pkg::t_q14       r_e00, r_e01, r_e02;
    ptfk_pkg::t_q14       r_e10, r_e11, r_e12;
    ptfk_pkg::t_q14       r_e20, r_e22;

    ptfk_pkg::t_q14       n_c1s2, n_s1s2;

    assign busy = 1'b0;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dh_model     <= 1'b0;
            r_output_frame <= 1'b0;
        end else if (i_cfg_we) begin
            case (ptfk_pkg::t_reg_idx'(i_cfg_idx))
                ptfk_pkg::t_REG_DH_MODEL:     r_dh_model     <= i_cfg_data[0];
                ptfk_pkg::t_REG_OUTPUT_FRAME: r_output_frame <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_angle[0] = i_pan_angle;
    assign w_angle[1] = i_tilt_angle;

    ptfk_sincos u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_angle (w_angle),
        .o_valid (w_sc_vld),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // Lane 0 carries the pan joint (c1, s1) and lane 1 the tilt joint (c2, s2).
    assign n_c1s2 = ptfk_pkg::mul14(w_cos[0], w_sin[1]);
    assign n_s1s2 = ptfk_pkg::mul14(w_sin[0], w_sin[1]);

    always_ff @(posedge i_clk) begin
        r_e01 <= -w_sin[0];
        r_e02 <= ptfk_pkg::mul14(w_cos[0], w_cos[1]);
        r_e11 <= w_cos[0];
        r_e12 <= ptfk_pkg::mul14(w_sin[0], w_cos[1]);
        r_e20 <= -w_cos[1];
        if (r_dh_model) begin
            r_e00 <= n_c1s2;
            r_e10 <= n_s1s2;
            r_e22 <= w_sin[1];
        end else begin
            r_e00 <= -n_c1s2;
            r_e10 <= -n_s1s2;
            r_e22 <= -w_sin[1];
        end
    end

    // Scales a first-column entry by the camera offset, rounding to nearest.
    function automatic ptfk_pkg::t_trans offset_of(input ptfk_pkg::t_q14 v);
        logic signed [32:0] p;
        p = ptfk_pkg::H_Q20 * v;
        p = p + 33'sd8192;
        return ptfk_pkg::t_trans'(p >>> 14);
    endfunction

    // Output stage: in camera frame the first two columns swap with a sign
    // change on the new second column, and the translation follows the old
    // first column. In end-effector frame the translation is zero.
    always_ff @(posedge i_clk) begin
        o_rot_r0c2 <= r_e02;
        o_rot_r1c2 <= r_e12;
        o_rot_r2c2 <= r_e22;
        if (r_output_frame) begin
            o_rot_r0c0 <= r_e01;
            o_rot_r0c1 <= -r_e00;
            o_rot_r1c0 <= r_e11;
            o_rot_r1c1 <= -r_e10;
            o_rot_r2c0 <= '0;
            o_rot_r2c1 <= -r_e20;
            o_trans_x  <= offset_of(r_e00);
            o_trans_y  <= offset_of(r_e10);
            o_trans_z  <= offset_of(r_e20);
        end else begin
            o_rot_r0c0 <= r_e00;
            o_rot_r0c1 <= r_e01;
            o_rot_r1c0 <= r_e10;
            o_rot_r1c1 <= r_e11;
            o_rot_r2c0 <= r_e20;
            o_rot_r2c1 <= '0;
            o_trans_x  <= '0;
            o_trans_y  <= '0;
            o_trans_z  <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_p_vld <= w_sc_vld;
            o_valid <= r_p_vld;
        end
    end

endmodule

FILE: bench/pan_tilt_forward_kinematics_unit_test.sv
// Self-checking testbench for the pan-tilt forward kinematics unit.
`timescale 1ns / 1ps

// The bench sends pan/tilt angle words through the command handshake and
// checks every result word against a bit-exact prediction worked out here.
// The prediction repeats the block's fixed-point recipe. The angle is folded
// by half a turn when it lies beyond a quarter turn. A CORDIC rotator then
// gives the cosine and sine, which are rounded to Q1.14 and clamped. These
// are combined into the rotation, with the table's signs set by the DH model
// in use. In the camera frame the first two columns are swapped with a sign
// change, and the translation is the camera offset times the first
// end-effector column.
//
// The run has a short directed part at the reset settings: range limits, the
// half-turn fold boundaries and codes beyond +-pi. Then come several random
// phases, and each phase begins by writing both registers while nothing is
// in flight. Between them the phases cover all four register settings.
// Gaps between words are random. Long calm stretches keep the pipeline full,
// so gaps land on every stage of its work.

module pan_tilt_forward_kinematics_unit_test;

    // Drain time covers the whole pipeline, with a margin on top.
    localparam int     DRAIN_CYCLES     = ptfk_pkg::CORDIC_STAGES + 12;
    localparam longint CYCLE_LIMIT      = 400000;
    localparam int     RANDOM_PER_PHASE = 180;
    localparam int     PHASES           = 5;
    localparam int     EDGE_COUNT       = 14;

    // Fixed-point constants of the recipe: angles in Q3.29, gain in Q29,
    // camera offset in units of 2^-20 m.
    localparam longint PI_Z      = 64'sd1686629713;
    localparam longint HALF_PI_Z = 64'sd843314857;
    localparam longint CORDIC_K  = 64'sd326016437;
    localparam longint OFFSET_H  = 64'sd50332;

    localparam longint ARCTAN_STEP [24] = '{
        421657428, 248918915, 131521918, 66762579,
        33510843,  16771758,  8387925,   4194219,
        2097141,   1048575,   524288,    262144,
        131072,    65536,     32768,     16384,
        8192,      4096,      2048,      1024,
        512,       256,       128,       64
    };

    // Interesting angle codes: zero, one step either way, either side of
    // the quarter-turn fold, either side of +-pi, the 16-bit limits and pi/4.
    localparam int EDGE_ANGLE [EDGE_COUNT] = '{
        0, 1, -1, 12867, 12868, -12867, -12868,
        25735, 25736, -25735, -25736, 32767, -32768, 6434
    };

    // Register settings of the random phases: bit 1 is dh_model and
    // bit 0 is output_frame. All four appear, and the phases end where
    // they started so each setting is also reached from another one.
    localparam logic [1:0] PHASE_MODE [PHASES] = '{2'b11, 2'b01, 2'b10, 2'b00, 2'b11};

    typedef struct packed {
        ptfk_pkg::t_angle pan;
        ptfk_pkg::t_angle tilt;
    } t_angle_pair;

    typedef struct {
        ptfk_pkg::t_q14   rot [9];
        ptfk_pkg::t_trans shift [3];
    } t_pose;

    // Everything the block sees is driven to a known value from time zero.
    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               start      = 1'b0;
    logic               busy;
    ptfk_pkg::t_angle   pan_angle  = '0;
    ptfk_pkg::t_angle   tilt_angle = '0;
    logic               cfg_we     = 1'b0;
    logic               cfg_idx    = 1'b0;
    logic               cfg_data   = 1'b0;
    logic               o_valid;
    ptfk_pkg::t_q14     rot_out [9];
    ptfk_pkg::t_trans   shift_out [3];

    // Mirror of the configuration registers as last written.
    bit second_model = 1'b0;
    bit camera_frame = 1'b0;

    t_angle_pair angles_pending [$];
    t_pose       poses_due [$];
    bit          in_hand    = 1'b0;
    int          gap_left   = 0;
    int          calm_left  = 0;
    int          gap_roll;
    int          fail_count = 0;
    longint      cycle_count = 0;

    pan_tilt_forward_kinematics_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_pan_angle  (pan_angle),
        .i_tilt_angle (tilt_angle),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_valid      (o_valid),
        .o_rot_r0c0   (rot_out[0]),
        .o_rot_r0c1   (rot_out[1]),
        .o_rot_r0c2   (rot_out[2]),
        .o_rot_r1c0   (rot_out[3]),
        .o_rot_r1c1   (rot_out[4]),
        .o_rot_r1c2   (rot_out[5]),
        .o_rot_r2c0   (rot_out[6]),
        .o_rot_r2c1   (rot_out[7]),
        .o_rot_r2c2   (rot_out[8]),
        .o_trans_x    (shift_out[0]),
        .o_trans_y    (shift_out[1]),
        .o_trans_z    (shift_out[2])
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Cosine and sine of a Q3.13 angle, both in Q1.14. Beyond a quarter
    // turn the angle is moved by half a turn and the rotated vector negated.
    function automatic void cordic_sincos(input longint ang, output longint c,
                                          output longint s);
        longint z, x, y, nx, ny;
        bit     flip;
        int     i;
        z    = ang * 65536;
        x    = CORDIC_K;
        y    = 0;
        flip = 1'b0;
        if (z > HALF_PI_Z) begin
            z    = z - PI_Z;
            flip = 1'b1;
        end else if (z < -HALF_PI_Z) begin
            z    = z + PI_Z;
            flip = 1'b1;
        end
        for (i = 0; i < ptfk_pkg::CORDIC_STAGES && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - ARCTAN_STEP[i];
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + ARCTAN_STEP[i];
            end
            x = nx;
            y = ny;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        // Rounding may overshoot unity by a step; it is clamped back.
        c = (x + 16384) >>> 15;
        s = (y + 16384) >>> 15;
        if (c > 16384) c = 16384;
        if (c < -16384) c = -16384;
        if (s > 16384) s = 16384;
        if (s < -16384) s = -16384;
    endfunction

    // Q1.14 product rounded to nearest, ties upwards.
    function automatic longint round_product(input longint a, input longint b);
        return (a * b + 8192) >>> 14;
    endfunction

    // Expected pose for one angle word under the current register settings.
    function automatic t_pose predict_pose(input ptfk_pkg::t_angle pan,
                                           input ptfk_pkg::t_angle tilt);
        longint c1, s1, c2, s2;
        longint e [3][3];
        t_pose  p;
        int     i;
        cordic_sincos(pan, c1, s1);
        cordic_sincos(tilt, c2, s2);
        e[0][1] = -s1;
        e[0][2] = round_product(c1, c2);
        e[1][1] = c1;
        e[1][2] = round_product(s1, c2);
        e[2][0] = -c2;
        e[2][1] = 0;
        // The sign of the tilt-sine terms is applied after rounding.
        if (second_model) begin
            e[0][0] = round_product(c1, s2);
            e[1][0] = round_product(s1, s2);
            e[2][2] = s2;
        end else begin
            e[0][0] = -round_product(c1, s2);
            e[1][0] = -round_product(s1, s2);
            e[2][2] = -s2;
        end
        for (i = 0; i < 3; i++) begin
            if (camera_frame) begin
                p.rot[3*i]   = ptfk_pkg::t_q14'(e[i][1]);
                p.rot[3*i+1] = ptfk_pkg::t_q14'(-e[i][0]);
                p.shift[i]   = ptfk_pkg::t_trans'((OFFSET_H * e[i][0] + 8192) >>> 14);
            end else begin
                p.rot[3*i]   = ptfk_pkg::t_q14'(e[i][0]);
                p.rot[3*i+1] = ptfk_pkg::t_q14'(e[i][1]);
                p.shift[i]   = '0;
            end
            p.rot[3*i+2] = ptfk_pkg::t_q14'(e[i][2]);
        end
        return p;
    endfunction

    // Mostly angles inside +-pi, with some raw 16-bit codes, some codes
    // close to the fold boundaries or to +-pi, and some of the edge codes themselves.
    function automatic ptfk_pkg::t_angle random_angle();
        int roll;
        int base;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return ptfk_pkg::t_angle'(int'($urandom_range(0, 2 * 25736)) - 25736);
        end else if (roll < 75) begin
            return ptfk_pkg::t_angle'($urandom);
        end else if (roll < 90) begin
            base = $urandom_range(0, 1) ? 12868 : 25736;
            if ($urandom_range(0, 1)) base = -base;
            return ptfk_pkg::t_angle'(base + int'($urandom_range(0, 8)) - 4);
        end
        return ptfk_pkg::t_angle'(EDGE_ANGLE[$urandom_range(0, EDGE_COUNT - 1)]);
    endfunction

    // A register write is taken at the edge that ends the cycle in which
    // the write enable is high; the mirror follows at that same edge.
    task automatic write_reg(input ptfk_pkg::t_reg_idx idx, input bit value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == ptfk_pkg::t_REG_DH_MODEL) begin
            second_model = value;
        end else begin
            camera_frame = value;
        end
    endtask

    // Waits until every queued word has been taken and every expected
    // result has come back, then lets the pipeline run dry.
    task automatic wait_idle();
        while (angles_pending.size() != 0 || in_hand || poses_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Driver: offers the next pending word, holds it while busy is high and
    // records the prediction at the edge where the word is taken. Between
    // words it inserts random gaps, with calm stretches of back-to-back words.
    always @(posedge i_clk) begin
        t_angle_pair word;
        if (!i_rst_n) begin
            start   <= 1'b0;
            in_hand = 1'b0;
        end else begin
            if (start && !busy) begin
                poses_due.push_back(predict_pose(pan_angle, tilt_angle));
                in_hand = 1'b0;
            end
            if (in_hand) begin
                // The word on offer stays put until the block takes it.
            end else if (gap_left > 0) begin
                start    <= 1'b0;
                gap_left = gap_left - 1;
            end else if (angles_pending.size() != 0) begin
                word = angles_pending.pop_front();
                pan_angle  <= word.pan;
                tilt_angle <= word.tilt;
                start      <= 1'b1;
                in_hand    = 1'b1;
                if (calm_left > 0) begin
                    calm_left = calm_left - 1;
                    gap_left  = 0;
                end else begin
                    gap_roll = $urandom_range(0, 99);
                    if (gap_roll < 4) calm_left = $urandom_range(20, 80);
                    if (gap_roll < 50) gap_left = 0;
                    else if (gap_roll < 88) gap_left = $urandom_range(1, 3);
                    else if (gap_roll < 97) gap_left = $urandom_range(4, 9);
                    else gap_left = $urandom_range(15, 40);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed result word is compared field by field with
    // the oldest prediction still waiting.
    always @(posedge i_clk) begin
        t_pose due;
        string axis;
        if (i_rst_n && o_valid) begin
            if (poses_due.size() == 0) begin
                $error("result word arrived with no prediction waiting");
                fail_count++;
            end else begin
                due = poses_due.pop_front();
                for (int k = 0; k < 9; k++) begin
                    if (rot_out[k] !== due.rot[k]) begin
                        $error("rot_r%0dc%0d: expected %0d, got %0d",
                               k / 3, k % 3, due.rot[k], rot_out[k]);
                        fail_count++;
                    end
                end
                for (int k = 0; k < 3; k++) begin
                    axis = (k == 0) ? "x" : (k == 1) ? "y" : "z";
                    if (shift_out[k] !== due.shift[k]) begin
                        $error("trans_%s: expected %0d, got %0d",
                               axis, due.shift[k], shift_out[k]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: well above the slowest correct run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** pan_tilt_forward_kinematics_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        t_angle_pair word;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset settings: each edge code paired with
        // itself and, for most of them, with a different edge code.
        for (int k = 0; k < EDGE_COUNT; k++) begin
            word.pan  = ptfk_pkg::t_angle'(EDGE_ANGLE[k]);
            word.tilt = ptfk_pkg::t_angle'(EDGE_ANGLE[k]);
            angles_pending.push_back(word);
            if (k < 10) begin
                word.tilt = ptfk_pkg::t_angle'(EDGE_ANGLE[(k * 5 + 3) % EDGE_COUNT]);
                angles_pending.push_back(word);
            end
        end
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(ptfk_pkg::t_REG_DH_MODEL, PHASE_MODE[ph][1]);
            write_reg(ptfk_pkg::t_REG_OUTPUT_FRAME, PHASE_MODE[ph][0]);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                word.pan  = random_angle();
                word.tilt = random_angle();
                angles_pending.push_back(word);
            end
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("** pan_tilt_forward_kinematics_unit: PASSED **");
        end else begin
            $display("** pan_tilt_forward_kinematics_unit: FAILED **");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/ptfk_pkg.sv
rtl/core/ptfk_sincos.sv
rtl/core/pan_tilt_forward_kinematics_unit.sv
bench/pan_tilt_forward_kinematics_unit_test.sv
